### rtl/y2r_pkg.sv
// shared constants and types for the yuyv to rgb888 converter
`default_nettype none

package y2r_pkg;

	localparam int NumerW = 21;

	localparam logic signed [NumerW-1:0] LUMA_GAIN    = 21'sd1164;
	localparam logic signed [NumerW-1:0] RED_V_GAIN   = 21'sd1159;
	localparam logic signed [NumerW-1:0] GREEN_U_GAIN = 21'sd380;
	localparam logic signed [NumerW-1:0] GREEN_V_GAIN = 21'sd813;
	localparam logic signed [NumerW-1:0] BLUE_U_GAIN  = 21'sd2018;
	localparam logic signed [9:0]        LUMA_OFFSET  = 10'sd16;
	localparam logic signed [9:0]        CHROMA_MID   = 10'sd128;

	// quotient above 255 starts at 256 * 1000
	localparam logic signed [NumerW-1:0] SAT_LIMIT = 21'sd256000;
	localparam logic [7:0]               CHAN_MAX  = 8'd255;

	// ceil(2^28 / 1000), exact floor for numerators below 256000
	localparam int                 DivShift  = 28;
	localparam int                 DivInW    = 18;
	localparam int                 ProdW     = 37;
	localparam logic [18:0]        DIV_RECIP = 19'd268436;

	typedef logic signed [NumerW-1:0] numer_t;

	typedef struct packed {
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

`default_nettype wire

### rtl/y2r_chdiv.sv
// clamp and divide-by-1000 of one color channel over two pipeline stages
`default_nettype none

module y2r_chdiv (
	input  wire                clk,
	input  y2r_pkg::stage_en_t en,
	input  y2r_pkg::numer_t    numer,
	output logic [7:0]         chan
);

	logic                        zero_s3;
	logic                        sat_s3;
	logic [y2r_pkg::ProdW-1:0]   prod_s3;
	logic [7:0]                  chan_s4;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			zero_s3 <= (numer <= 0);
			sat_s3  <= (numer >= y2r_pkg::SAT_LIMIT);
			prod_s3 <= y2r_pkg::ProdW'(numer[y2r_pkg::DivInW-1:0])
				* y2r_pkg::ProdW'(y2r_pkg::DIV_RECIP);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			priority if (zero_s3) begin
				chan_s4 <= '0;
			end else if (sat_s3) begin
				chan_s4 <= y2r_pkg::CHAN_MAX;
			end else begin
				chan_s4 <= prod_s3[y2r_pkg::DivShift +: 8];
			end
		end
	end

	assign chan = chan_s4;

endmodule

`default_nettype wire

### rtl/yuyv_to_rgb888_converter.sv
// top level: yuyv macropixel to two rgb888 pixels, integer coefficients scaled by 1000
`default_nettype none

// Converts one YUYV macropixel per transfer into two RGB888 pixels that share
// the chroma pair. Four register stages: constant products, channel
// numerators, reciprocal multiply for the divide by 1000 with clamp flags,
// and the output register. A new macropixel is taken every clock while the
// output side keeps up; the result is registered in each stage in turn
// before it reaches the output register. A stall holds only the stages
// that are full, so bubbles are squeezed out and no item is lost or
// repeated. frame_done follows frame_end of the same item.
module yuyv_to_rgb888_converter (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        pixel_valid,
	output logic       pixel_ready,
	input  wire [7:0]  luma_first,
	input  wire [7:0]  chroma_blue,
	input  wire [7:0]  luma_second,
	input  wire [7:0]  chroma_red,
	input  wire        frame_end,
	output logic       rgb_valid,
	input  wire        rgb_ready,
	output logic [7:0] red_first,
	output logic [7:0] green_first,
	output logic [7:0] blue_first,
	output logic [7:0] red_second,
	output logic [7:0] green_second,
	output logic [7:0] blue_second,
	output logic       frame_done
);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic en_s1, en_s2;
	y2r_pkg::stage_en_t en;

	logic signed [9:0] y0_m, y1_m, u_m, v_m;

	y2r_pkg::numer_t base0_s1, base1_s1, red_t_s1, gu_t_s1, gv_t_s1, blue_t_s1;
	y2r_pkg::numer_t rf_s2, gf_s2, bf_s2, rs_s2, gs_s2, bs_s2;
	logic frame_s1, frame_s2, frame_s3, frame_s4;

	// a stage loads when it is empty or its contents move on
	assign en.s4 = !vld_s4 || rgb_ready;
	assign en.s3 = !vld_s3 || en.s4;
	assign en_s2 = !vld_s2 || en.s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign pixel_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				vld_s1 <= pixel_valid;
			end
			if (en_s2) begin
				vld_s2 <= vld_s1;
			end
			if (en.s3) begin
				vld_s3 <= vld_s2;
			end
			if (en.s4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	assign y0_m = $signed({2'b00, luma_first})  - y2r_pkg::LUMA_OFFSET;
	assign y1_m = $signed({2'b00, luma_second}) - y2r_pkg::LUMA_OFFSET;
	assign u_m  = $signed({2'b00, chroma_blue}) - y2r_pkg::CHROMA_MID;
	assign v_m  = $signed({2'b00, chroma_red})  - y2r_pkg::CHROMA_MID;

	// stage 1: constant products
	always_ff @(posedge clk) begin
		if (en_s1) begin
			base0_s1  <= y2r_pkg::numer_t'(y0_m) * y2r_pkg::LUMA_GAIN;
			base1_s1  <= y2r_pkg::numer_t'(y1_m) * y2r_pkg::LUMA_GAIN;
			red_t_s1  <= y2r_pkg::numer_t'(v_m) * y2r_pkg::RED_V_GAIN;
			gu_t_s1   <= y2r_pkg::numer_t'(u_m) * y2r_pkg::GREEN_U_GAIN;
			gv_t_s1   <= y2r_pkg::numer_t'(v_m) * y2r_pkg::GREEN_V_GAIN;
			blue_t_s1 <= y2r_pkg::numer_t'(u_m) * y2r_pkg::BLUE_U_GAIN;
			frame_s1  <= frame_end;
		end
	end

	// stage 2: channel numerators
	always_ff @(posedge clk) begin
		if (en_s2) begin
			rf_s2    <= base0_s1 + red_t_s1;
			gf_s2    <= base0_s1 - gu_t_s1 - gv_t_s1;
			bf_s2    <= base0_s1 + blue_t_s1;
			rs_s2    <= base1_s1 + red_t_s1;
			gs_s2    <= base1_s1 - gu_t_s1 - gv_t_s1;
			bs_s2    <= base1_s1 + blue_t_s1;
			frame_s2 <= frame_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			frame_s3 <= frame_s2;
		end
		if (en.s4) begin
			frame_s4 <= frame_s3;
		end
	end

	// stages 3 and 4: divide and clamp per channel
	y2r_chdiv u_rf (.clk(clk), .en(en), .numer(rf_s2), .chan(red_first));
	y2r_chdiv u_gf (.clk(clk), .en(en), .numer(gf_s2), .chan(green_first));
	y2r_chdiv u_bf (.clk(clk), .en(en), .numer(bf_s2), .chan(blue_first));
	y2r_chdiv u_rs (.clk(clk), .en(en), .numer(rs_s2), .chan(red_second));
	y2r_chdiv u_gs (.clk(clk), .en(en), .numer(gs_s2), .chan(green_second));
	y2r_chdiv u_bs (.clk(clk), .en(en), .numer(bs_s2), .chan(blue_second));

	assign rgb_valid  = vld_s4;
	assign frame_done = frame_s4;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_ready |=> vld_s1)
		else $error("accepted macropixel did not reach stage 1");

	a_backpressure_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_ready |-> vld_s1 && vld_s2 && vld_s3 && vld_s4)
		else $error("input stalled while the pipeline has a bubble");

	a_stall_holds_s2: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !en.s3 |=> vld_s2 && $stable(rf_s2) && $stable(frame_s2))
		else $error("stalled stage 2 item changed or was dropped");

	a_stall_holds_s3: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && !en.s4 |=> vld_s3 && $stable(frame_s3))
		else $error("stalled stage 3 item changed or was dropped");

endmodule

`default_nettype wire
